// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types, character codes and lookup functions
// Holds the result word layout, the status codes and the small decode tables
// used by the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Most bytes one input word can produce (a three byte UTF-8 sequence).
  localparam int MaxBurst = 3;
  localparam int CountW   = $clog2(MaxBurst + 1);

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ESC   = 2'd1,
    ST_SHORT_HEX = 2'd2,
    ST_BAD_HEX   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_t    status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [CountW-1:0]        count;
    res_t [MaxBurst-1:0]      item;
  } burst_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  // Returns {is_simple_escape, decoded byte} for the letter after a backslash.
  function automatic logic [8:0] esc_byte(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_T:                       r = {1'b1, 8'h09};
      CH_R:                       r = {1'b1, 8'h0D};
      CH_N:                       r = {1'b1, 8'h0A};
      CH_B:                       r = {1'b1, 8'h08};
      CH_F:                       r = {1'b1, 8'h0C};
      CH_0:                       r = {1'b1, 8'h00};
      CH_BSL, CH_SLASH, CH_QUOTE: r = {1'b1, c};
      default:                    r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jsu_in_if.sv =====
// ----------------------------------------------------------------------------
// jsu_in_if: escaped text input channel
// Valid/ready channel that carries one byte of escaped string text per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jsu_out_if.sv =====
// ----------------------------------------------------------------------------
// jsu_out_if: decoded result channel
// Valid/ready channel that carries one decoded byte and its status per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] status;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output status,
                  output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input status,
                  input out_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/json_string_unescaper.sv =====
// An accepted input word is held in the input register, then its results in the result register.
// Throughput: one input word per cycle while the output is not stalled; a \u
// escape that encodes to two or three UTF-8 bytes holds the input while the
// result register drains, one byte per cycle while the output is ready.
// Reset: synchronous, active high; clears the escape phase, the partial code
// point, the input register's valid flag and the result register's word count.
// ----------------------------------------------------------------------------
// json_string_unescaper: streaming JSON string escape decoder
// Takes escaped string text a byte at a time and gives the decoded bytes,
// with \u escapes re-encoded as UTF-8 and errors reported once per string.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescaper (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  // Input register. It is refilled in the same cycle it is consumed, so a
  // full stream goes through without bubbles.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  burst_t     burst;
  logic       can_load;
  logic       advance;
  logic       load;

  // The held word moves on when its results fit in the result register.
  // Words that only advance the escape state give no results and always
  // move on.
  assign advance     = hold_valid && ((burst.count == '0) || can_load);
  assign load        = advance && (burst.count != '0);
  assign in_ch.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_byte <= in_ch.in_byte;
      hold_last <= in_ch.in_last;
    end
  end

  // Escape state machine and UTF-8 encoder between the two registers.
  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .item_byte (hold_byte),
    .item_last (hold_last),
    .advance   (advance),
    .burst     (burst)
  );

  // Result register; it drains a multi-byte burst one word per cycle while the receiver is ready.
  jsu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst    (burst),
    .can_load (can_load),
    .o        (out_ch)
  );

`ifndef NO_ASSERTIONS
  // An error report never carries a decoded byte.
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status != ST_OK) |-> !out_ch.out_valid)
    else $error("error word carries a decoded byte");

  // A word without data is either an error report or the end marker of a
  // dropped string.
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.out_valid |-> (out_ch.status != ST_OK) || out_ch.out_last)
    else $error("empty result word that is neither error nor end marker");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result offered right after reset");

  // The result register never loads over words still waiting to be sent.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("result register loaded while words still pending");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode: escape state machine and UTF-8 encoder
// Turns the held input word into zero to three result words and keeps the
// escape phase and the partial code point.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       item_byte,
  input  logic             item_last,
  input  logic             advance,
  output jsu_pkg::burst_t  burst
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    PH_PLAIN = 7'b0000001,
    PH_ESC   = 7'b0000010,
    PH_HEX0  = 7'b0000100,
    PH_HEX1  = 7'b0001000,
    PH_HEX2  = 7'b0010000,
    PH_HEX3  = 7'b0100000,
    PH_DROP  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [11:0] cp, cp_next;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] full_cp;
  logic        fail_en;
  status_t     fail_st;

  always_comb begin
    burst      = '0;
    phase_next = phase;
    cp_next    = cp;
    fail_en    = 1'b0;
    fail_st    = ST_OK;
    hex        = hex_digit(item_byte);
    esc        = esc_byte(item_byte);
    full_cp    = {cp, hex[3:0]};

    case (phase)
      PH_PLAIN: begin
        if (item_byte != CH_BSL) begin
          burst.count   = CountW'(1);
          burst.item[0] = '{data: item_byte, valid: 1'b1, status: ST_OK, last: item_last};
        end else if (item_last) begin
          fail_en = 1'b1;
          fail_st = ST_BAD_ESC;
        end else begin
          phase_next = PH_ESC;
        end
      end
      PH_ESC: begin
        if (esc[8]) begin
          burst.count   = CountW'(1);
          burst.item[0] = '{data: esc[7:0], valid: 1'b1, status: ST_OK, last: item_last};
          phase_next    = PH_PLAIN;
        end else if (item_byte == CH_U) begin
          if (item_last) begin
            fail_en = 1'b1;
            fail_st = ST_SHORT_HEX;
          end else begin
            phase_next = PH_HEX0;
            cp_next    = '0;
          end
        end else begin
          fail_en = 1'b1;
          fail_st = ST_BAD_ESC;
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2: begin
        if (item_last) begin
          fail_en = 1'b1;
          fail_st = ST_SHORT_HEX;
        end else if (!hex[4]) begin
          fail_en = 1'b1;
          fail_st = ST_BAD_HEX;
        end else begin
          cp_next = {cp[7:0], hex[3:0]};
          case (phase)
            PH_HEX0: phase_next = PH_HEX1;
            PH_HEX1: phase_next = PH_HEX2;
            default: phase_next = PH_HEX3;
          endcase
        end
      end
      PH_HEX3: begin
        if (!hex[4]) begin
          fail_en = 1'b1;
          fail_st = ST_BAD_HEX;
        end else begin
          phase_next = PH_PLAIN;
          cp_next    = '0;
          if (full_cp < 16'h0080) begin
            burst.count   = CountW'(1);
            burst.item[0] = '{data: full_cp[7:0], valid: 1'b1, status: ST_OK,
                              last: item_last};
          end else if (full_cp < 16'h0800) begin
            burst.count   = CountW'(2);
            burst.item[0] = '{data: {3'b110, full_cp[10:6]}, valid: 1'b1,
                              status: ST_OK, last: 1'b0};
            burst.item[1] = '{data: {2'b10, full_cp[5:0]}, valid: 1'b1,
                              status: ST_OK, last: item_last};
          end else begin
            burst.count   = CountW'(3);
            burst.item[0] = '{data: {4'b1110, full_cp[15:12]}, valid: 1'b1,
                              status: ST_OK, last: 1'b0};
            burst.item[1] = '{data: {2'b10, full_cp[11:6]}, valid: 1'b1,
                              status: ST_OK, last: 1'b0};
            burst.item[2] = '{data: {2'b10, full_cp[5:0]}, valid: 1'b1,
                              status: ST_OK, last: item_last};
          end
        end
      end
      default: begin
        // Dropping after an error: only the last byte gives a marker word.
        if (item_last) begin
          burst.count   = CountW'(1);
          burst.item[0] = '{data: 8'h00, valid: 1'b0, status: ST_OK, last: 1'b1};
          phase_next    = PH_PLAIN;
        end else begin
          phase_next = PH_DROP;
        end
      end
    endcase

    if (fail_en) begin
      burst.count   = CountW'(1);
      burst.item[0] = '{data: 8'h00, valid: 1'b0, status: fail_st, last: item_last};
      phase_next    = item_last ? PH_PLAIN : PH_DROP;
      cp_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
      cp    <= '0;
    end else if (advance) begin
      phase <= phase_next;
      cp    <= cp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_out_buf.sv =====
// ----------------------------------------------------------------------------
// jsu_out_buf: result register
// Holds the words of one decoded input word and sends them one per cycle while o.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsu_pkg::burst_t burst,
  output logic            can_load,
  jsu_out_if.source       o
);
  import jsu_pkg::*;

  logic [CountW-1:0]   count;
  res_t [MaxBurst-1:0] slot;
  logic                pop;

  assign pop      = o.valid && o.ready;
  assign can_load = (count == '0) || ((count == CountW'(1)) && o.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (pop) begin
      count <= count - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= burst.item;
    end else if (pop) begin
      for (int i = 0; i < MaxBurst - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign o.valid     = (count != '0);
  assign o.out_byte  = slot[0].data;
  assign o.out_valid = slot[0].valid;
  assign o.status    = slot[0].status;
  assign o.out_last  = slot[0].last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_json_string_unescaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescaper: self-checking regression for the JSON unescaper
// Streams escaped string text into the block and predicts every decoded word:
// plain bytes, simple escapes, u escapes re-encoded as UTF-8, and the error
// and drop handling. Both channels idle and stall at random throughout.
// ----------------------------------------------------------------------------

module tb_json_string_unescaper;
  import jsu_pkg::*;

  // Scan position inside the escaped text, as the predictor tracks it.
  typedef enum logic [1:0] {
    SCAN_TEXT,
    SCAN_ESCAPE,
    SCAN_HEX,
    SCAN_DROP
  } scan_t;

  localparam int CycleLimit  = 400000;
  localparam int RandomWords = 300;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 10;

  // Every letter that forms a simple two-byte escape.
  localparam logic [7:0] EscLetters [9] = '{CH_T, CH_R, CH_N, CH_B, CH_F, CH_0,
                                             CH_BSL, CH_SLASH, CH_QUOTE};

  // Predicts the decoded words from the accepted text words and checks the
  // words that come out of the block against them, oldest first.
  class unescape_scoreboard;
    res_t  decoded_q[$];
    int    errors;
    scan_t scan;
    int    digits;
    logic [15:0] code_point;

    function new();
      errors     = 0;
      scan       = SCAN_TEXT;
      digits     = 0;
      code_point = '0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void push_decoded(logic [7:0] data, logic valid, status_t st, logic lst);
      res_t r;
      r.data   = data;
      r.valid  = valid;
      r.status = st;
      r.last   = lst;
      decoded_q.push_back(r);
    endfunction

    // An error gives a single word with no data. Unless the string ends here,
    // the rest of the string is dropped.
    function void flag_error(status_t st, logic lst);
      push_decoded(8'h00, 1'b0, st, lst);
      scan = lst ? SCAN_TEXT : SCAN_DROP;
    endfunction

    // Notes one accepted text word and queues the words it should produce.
    function void note_text(logic [7:0] c, logic lst);
      logic [7:0] lit;
      logic       known;
      logic       is_hex;
      logic [3:0] nib;
      lit    = 8'h00;
      known  = 1'b1;
      is_hex = 1'b1;
      nib    = 4'h0;
      case (scan)
        SCAN_TEXT: begin
          if (c != CH_BSL) begin
            push_decoded(c, 1'b1, ST_OK, lst);
          end else if (lst) begin
            flag_error(ST_BAD_ESC, 1'b1);
          end else begin
            scan = SCAN_ESCAPE;
          end
        end
        SCAN_ESCAPE: begin
          // Control codes: tab, carriage return, line feed, backspace, form feed, NUL.
          case (c)
            CH_T:                       lit = 8'h09;
            CH_R:                       lit = 8'h0D;
            CH_N:                       lit = 8'h0A;
            CH_B:                       lit = 8'h08;
            CH_F:                       lit = 8'h0C;
            CH_0:                       lit = 8'h00;
            CH_BSL, CH_SLASH, CH_QUOTE: lit = c;
            default:                    known = 1'b0;
          endcase
          if (c == CH_U) begin
            if (lst) begin
              flag_error(ST_SHORT_HEX, 1'b1);
            end else begin
              scan       = SCAN_HEX;
              digits     = 0;
              code_point = '0;
            end
          end else if (!known) begin
            flag_error(ST_BAD_ESC, lst);
          end else begin
            push_decoded(lit, 1'b1, ST_OK, lst);
            scan = SCAN_TEXT;
          end
        end
        SCAN_HEX: begin
          if (c >= CH_0 && c <= CH_9) begin
            nib = 4'(c - CH_0);
          end else if (c >= CH_LA && c <= CH_LF) begin
            nib = 4'(c - CH_LA + 8'd10);
          end else if (c >= CH_UA && c <= CH_UF) begin
            nib = 4'(c - CH_UA + 8'd10);
          end else begin
            is_hex = 1'b0;
          end
          // A string that ends early wins over a bad digit on its last byte.
          if (digits < 3 && lst) begin
            flag_error(ST_SHORT_HEX, 1'b1);
          end else if (!is_hex) begin
            flag_error(ST_BAD_HEX, lst);
          end else begin
            code_point = {code_point[11:0], nib};
            if (digits < 3) begin
              digits++;
            end else begin
              if (code_point < 16'h0080) begin
                push_decoded(code_point[7:0], 1'b1, ST_OK, lst);
              end else if (code_point < 16'h0800) begin
                push_decoded({3'b110, code_point[10:6]}, 1'b1, ST_OK, 1'b0);
                push_decoded({2'b10, code_point[5:0]}, 1'b1, ST_OK, lst);
              end else begin
                // Surrogates land here too; each one is encoded on its own.
                push_decoded({4'b1110, code_point[15:12]}, 1'b1, ST_OK, 1'b0);
                push_decoded({2'b10, code_point[11:6]}, 1'b1, ST_OK, 1'b0);
                push_decoded({2'b10, code_point[5:0]}, 1'b1, ST_OK, lst);
              end
              scan = SCAN_TEXT;
            end
          end
        end
        default: begin
          // Dropping: silent until the last byte closes the string.
          if (lst) begin
            push_decoded(8'h00, 1'b0, ST_OK, 1'b1);
            scan = SCAN_TEXT;
          end
        end
      endcase
    endfunction

    function void match_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %h, actual %h", name, want, got);
      end
    endfunction

    // Checks one accepted result word against the oldest prediction.
    function void check_decoded(res_t got);
      res_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $error("unexpected result word: out_byte %h", got.data);
        return;
      end
      want = decoded_q.pop_front();
      match_field("out_byte", want.data, got.data);
      match_field("out_valid", 8'(want.valid), 8'(got.valid));
      match_field("status", 8'(want.status), 8'(got.status));
      match_field("out_last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  jsu_in_if  text_ch ();
  jsu_out_if dec_ch ();

  json_string_unescaper DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (text_ch),
    .out_ch (dec_ch)
  );

  always #1 clk = ~clk;

  unescape_scoreboard sb = new();

  logic [7:0] text_q[$];
  int         burst_left = 0;
  int         words_sent = 0;
  int         cycle_count = 0;
  bit         hold_req = 1'b0;

  // Watchdog: a hang on either channel ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("json_string_unescaper regression: fail");
      $finish;
    end
  end

  // Receiver. Each word is sampled on the edge where it is accepted, then
  // ready is set for the next cycle. The stall pattern switches between
  // always ready, coin flip, mostly stalled and toggling. A hold request
  // from the stimulus keeps ready low for a long stretch so the block fills.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    res_t got;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    dec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && dec_ch.valid && dec_ch.ready) begin
        got.data   = dec_ch.out_byte;
        got.valid  = dec_ch.out_valid;
        got.status = status_t'(dec_ch.status);
        got.last   = dec_ch.out_last;
        sb.check_decoded(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(3);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        dec_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       dec_ch.ready <= 1'b1;
          1:       dec_ch.ready <= 1'($urandom_range(1));
          2:       dec_ch.ready <= ($urandom_range(3) == 0);
          default: dec_ch.ready <= !dec_ch.ready;
        endcase
      end
    end
  end

  // Offers one text word and returns on the edge where it is accepted. The
  // sender runs in bursts; between bursts valid may drop for a random gap.
  // Valid stays high after the accept, so the caller either sends the next
  // word in the same step or calls stop_text.
  task automatic send_word(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_ch.valid   <= 1'b1;
    text_ch.in_byte <= b;
    text_ch.in_last <= lst;
    do @(posedge clk); while (!text_ch.ready);
    sb.note_text(b, lst);
    words_sent++;
  endtask

  task automatic stop_text();
    text_ch.valid <= 1'b0;
  endtask

  // Sends the queued string, marking its final byte as last.
  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'(CH_0 + v);
    return 8'((($urandom_range(1) != 0) ? CH_LA : CH_UA) + v - 8'd10);
  endfunction

  function automatic void push_u_escape(logic [15:0] cp);
    text_q.push_back(CH_BSL);
    text_q.push_back(CH_U);
    for (int k = 3; k >= 0; k--) text_q.push_back(hex_char(cp[k*4 +: 4]));
  endfunction

  // Builds one random string. Most of it is well-formed text with random
  // content; the rest is bad escapes, bad digits, raw noise and strings cut
  // off at an arbitrary byte, often in the middle of an escape.
  function automatic void build_random_text();
    int tokens;
    int pick;
    int cut;
    logic [7:0]  b;
    logic [15:0] cp;
    text_q.delete();
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        b = 8'($urandom_range(255));
        text_q.push_back(b);
        if (b == CH_BSL) text_q.push_back(CH_BSL);
      end else if (pick < 65) begin
        text_q.push_back(CH_BSL);
        text_q.push_back(EscLetters[$urandom_range(8)]);
      end else if (pick < 85) begin
        // Spread code points over the one, two and three byte encodings.
        case ($urandom_range(2))
          0:       cp = 16'($urandom_range(16'h007F));
          1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
          default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        push_u_escape(cp);
      end else begin
        case ($urandom_range(2))
          0: begin
            text_q.push_back(CH_BSL);
            text_q.push_back(8'($urandom_range(255)));
          end
          1: begin
            push_u_escape(16'($urandom));
            text_q[text_q.size() - 1 - $urandom_range(3)] = 8'($urandom_range(255));
          end
          default: begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
          end
        endcase
      end
    end
    if ($urandom_range(9) == 0 && text_q.size() > 1) begin
      cut = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
  endfunction

  initial begin
    int strings_sent;
    strings_sent = 0;
    rst             <= 1'b1;
    text_ch.valid   <= 1'b0;
    text_ch.in_byte <= 8'h00;
    text_ch.in_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Extremes of plain bytes.
    text_q = '{8'h00, 8'hFF};
    send_text();
    // Simple escapes, ending on the zero escape.
    text_q = '{CH_BSL, CH_T, CH_BSL, CH_QUOTE, CH_BSL, CH_0};
    send_text();
    // Largest two-byte code point with mixed-case digits (u07fF).
    text_q = '{CH_BSL, CH_U, CH_0, 8'h37, CH_LF, CH_UF};
    send_text();
    // A lone high surrogate (uD800) encodes as three bytes; then a plain 'A'.
    text_q = '{CH_BSL, CH_U, 8'h44, 8'h38, CH_0, CH_0, 8'h41};
    send_text();
    // A backslash as the last byte of a string.
    text_q = '{CH_BSL};
    send_text();
    // Bad escape letter 'x', then bytes dropped up to the last one.
    text_q = '{CH_BSL, 8'h78, 8'h61, 8'h62};
    send_text();
    // String ends right after the u, and after one hex digit.
    text_q = '{CH_BSL, CH_U};
    send_text();
    text_q = '{CH_BSL, CH_U, 8'h31};
    send_text();
    // Bad hex digit 'g' reported at once, then dropped up to the last byte.
    text_q = '{CH_BSL, CH_U, 8'h67, 8'h7A};
    send_text();

    // Random part.
    while (words_sent < RandomWords + 35) begin
      build_random_text();
      send_text();
      strings_sent++;
      if (strings_sent == 10) begin
        // Long receiver hold while the sender keeps offering words.
        hold_req = 1'b1;
      end else if (strings_sent == 30) begin
        // Sender pause until every predicted word has come out.
        stop_text();
        do @(posedge clk); while (sb.pending() != 0);
      end
    end
    stop_text();

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("json_string_unescaper regression: pass");
    end else begin
      $display("json_string_unescaper regression: fail");
    end
    $finish;
  end

endmodule
